// ===== rtl/lwpg_pkg.sv =====
// Shared types, constants and the divider step for the LED wave phase generator.
package lwpg_pkg;

   localparam int TIME_W    = 48;
   localparam int PERIOD_W  = 32;
   localparam int GAIN_W    = 24;
   localparam int DIR_W     = 16;
   localparam int POS_W     = 16;
   localparam int PHASE_W   = 8;
   localparam int TERM_W    = 19;
   localparam int CSR_IDX_W = 3;

   localparam int MOD_STEPS  = TIME_W;
   localparam int QUOT_STEPS = PHASE_W;
   localparam int DIV_LAT    = MOD_STEPS + 1 + QUOT_STEPS;
   localparam int PROJ_LAT   = 4;
   localparam int TERM_DLY   = DIV_LAT - PROJ_LAT;

   // 255 * 520: lifts every phase sum above zero without changing it mod 255
   localparam logic [18:0] MOD_OFFSET = 19'd132600;

   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_COS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_SIN    = 3'd4;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   // One restoring division step: {quotient bit, new remainder}.
   function automatic logic [PERIOD_W:0] rem_step(input logic [PERIOD_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [PERIOD_W-1:0] divisor);
      logic [PERIOD_W:0] t;
      logic [PERIOD_W:0] d;
      logic [PERIOD_W:0] diff;
      t = {rem, bit_in};
      d = {1'b0, divisor};
      diff = t - d;
      if (t >= d) begin
         rem_step = {1'b1, diff[PERIOD_W-1:0]};
      end else begin
         rem_step = {1'b0, t[PERIOD_W-1:0]};
      end
   endfunction

endpackage

// ===== rtl/lwpg_if.sv =====
// Valid/ready channel interfaces for LED words and phase words.
interface lwpg_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] now_ms;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic        last_led;
   modport source (output valid, now_ms, pos_x, pos_y, last_led, input ready);
   modport sink   (input valid, now_ms, pos_x, pos_y, last_led, output ready);
endinterface

interface lwpg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] phase;
   logic       frame_end;
   modport source (output valid, phase, frame_end, input ready);
   modport sink   (input valid, phase, frame_end, output ready);
endinterface

// ===== rtl/lwpg_div.sv =====
// Pipelined elapsed-mod-period and phase-scale divider, one bit per stage.
module lwpg_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  lwpg_pkg::tag_type                in_tag,
   input  logic [lwpg_pkg::TIME_W-1:0]      in_elapsed,
   input  logic [lwpg_pkg::PERIOD_W-1:0]    period,
   output lwpg_pkg::tag_type                out_tag,
   output logic [lwpg_pkg::PHASE_W-1:0]     out_tphase
);
   import lwpg_pkg::*;

   tag_type              mtag_ff [MOD_STEPS];
   logic [PERIOD_W-1:0]  mrem_ff [MOD_STEPS];
   logic [TIME_W-1:0]    mdiv_ff [MOD_STEPS];

   tag_type              stag_ff;
   logic [PERIOD_W-1:0]  srem_ff;
   logic [7:0]           slo_ff;

   tag_type              qtag_ff [QUOT_STEPS];
   logic [PERIOD_W-1:0]  qrem_ff [QUOT_STEPS];
   logic [7:0]           qlo_ff  [QUOT_STEPS];
   logic [PHASE_W-1:0]   qq_ff   [QUOT_STEPS];

   // elapsed mod period, one dividend bit per stage
   for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
      tag_type             tag_prev;
      logic [PERIOD_W-1:0] rem_prev;
      logic [TIME_W-1:0]   div_prev;
      logic [PERIOD_W:0]   step;
      logic [PERIOD_W-1:0] mrem_in;
      logic [TIME_W-1:0]   mdiv_in;

      if (k == 0) begin : g_first
         assign tag_prev = in_tag;
         assign rem_prev = '0;
         assign div_prev = in_elapsed;
      end else begin : g_next
         assign tag_prev = mtag_ff[k-1];
         assign rem_prev = mrem_ff[k-1];
         assign div_prev = mdiv_ff[k-1];
      end

      assign step    = rem_step(rem_prev, div_prev[TIME_W-1], period);
      assign mrem_in = step[PERIOD_W-1:0];
      assign mdiv_in = {div_prev[TIME_W-2:0], 1'b0};

      always_ff @(posedge clock) begin
         if (reset) begin
            mtag_ff[k] <= '0;
         end else if (en) begin
            mtag_ff[k] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            mrem_ff[k] <= mrem_in;
            mdiv_ff[k] <= mdiv_in;
         end
      end
   end

   // loop * 255 = loop * 256 - loop; the top part is already below period
   logic [PERIOD_W+7:0] scaled;
   assign scaled = {mrem_ff[MOD_STEPS-1], 8'h00} - {8'h00, mrem_ff[MOD_STEPS-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         stag_ff <= '0;
      end else if (en) begin
         stag_ff <= mtag_ff[MOD_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         srem_ff <= scaled[PERIOD_W+7:8];
         slo_ff  <= scaled[7:0];
      end
   end

   for (genvar j = 0; j < QUOT_STEPS; j++) begin : g_quot
      tag_type             tag_prev;
      logic [PERIOD_W-1:0] rem_prev;
      logic [7:0]          lo_prev;
      logic [PHASE_W-1:0]  q_prev;
      logic [PERIOD_W:0]   step;

      if (j == 0) begin : g_first
         assign tag_prev = stag_ff;
         assign rem_prev = srem_ff;
         assign lo_prev  = slo_ff;
         assign q_prev   = '0;
      end else begin : g_next
         assign tag_prev = qtag_ff[j-1];
         assign rem_prev = qrem_ff[j-1];
         assign lo_prev  = qlo_ff[j-1];
         assign q_prev   = qq_ff[j-1];
      end

      assign step = rem_step(rem_prev, lo_prev[7], period);

      always_ff @(posedge clock) begin
         if (reset) begin
            qtag_ff[j] <= '0;
         end else if (en) begin
            qtag_ff[j] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            qrem_ff[j] <= step[PERIOD_W-1:0];
            qlo_ff[j]  <= {lo_prev[6:0], 1'b0};
            qq_ff[j]   <= {q_prev[PHASE_W-2:0], step[PERIOD_W]};
         end
      end
   end

   assign out_tag    = qtag_ff[QUOT_STEPS-1];
   // zero period means no time phase
   assign out_tphase = (period == '0) ? '0 : qq_ff[QUOT_STEPS-1];

endmodule

// ===== rtl/lwpg_proj.sv =====
// Four-stage projection of the LED position on the wave direction, scaled by gain.
module lwpg_proj (
   input  logic                               clock,
   input  logic                               en,
   input  logic [lwpg_pkg::POS_W-1:0]         pos_x,
   input  logic [lwpg_pkg::POS_W-1:0]         pos_y,
   input  logic signed [lwpg_pkg::DIR_W-1:0]  dir_cos,
   input  logic signed [lwpg_pkg::DIR_W-1:0]  dir_sin,
   input  logic [lwpg_pkg::GAIN_W-1:0]        wave_gain,
   output logic signed [lwpg_pkg::TERM_W-1:0] term
);
   import lwpg_pkg::*;

   logic signed [17:0] lx;
   logic signed [17:0] ly;
   logic signed [33:0] px_in, py_in, px_ff, py_ff;
   logic signed [33:0] dot_in, dot_ff;
   logic signed [58:0] pg_in, pg_ff;
   logic signed [58:0] biased;
   logic signed [TERM_W-1:0] term_ff;

   // centre the position: 2*pos - 1 in Q.16
   assign lx = $signed({1'b0, pos_x, 1'b0}) - 18'sh10000;
   assign ly = $signed({1'b0, pos_y, 1'b0}) - 18'sh10000;

   assign px_in  = 34'(dir_cos) * 34'(lx);
   assign py_in  = 34'(dir_sin) * 34'(ly);
   assign dot_in = px_ff + py_ff;
   assign pg_in  = 59'(dot_ff) * $signed({35'd0, wave_gain});
   // truncate toward zero: bias negatives before the shift
   assign biased = pg_ff + (pg_ff[58] ? 59'sh7F_FFFF_FFFF : 59'sd0);

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         dot_ff  <= dot_in;
         pg_ff   <= pg_in;
         term_ff <= biased[57:39];
      end
   end

   assign term = term_ff;

endmodule

// ===== rtl/led_wave_phase_generator_unit.sv =====
// Top level of the LED wave phase generator: registers, pipeline and output stage.
// One LED word enters per cycle unless the result side stalls; words leave in order of
// acceptance, and the pipeline holds 60 words in flight. The depth is set by the divider
// that reduces elapsed time modulo the period and scales it to 0..254, one quotient
// bit per stage. A stall on the result side freezes the whole pipeline: req ready
// is high whenever the output register is empty or is being read in that cycle.
module led_wave_phase_generator_unit (
   input  logic                                clock,
   input  logic                                reset,
   lwpg_req_if.sink                            req_chan,
   lwpg_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [lwpg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lwpg_pkg::TIME_W-1:0]         csr_wdata
);
   import lwpg_pkg::*;

   logic [TIME_W-1:0]        start_time_ff;
   logic [PERIOD_W-1:0]      period_ff;
   logic [GAIN_W-1:0]        wave_gain_ff;
   logic signed [DIR_W-1:0]  dir_cos_ff;
   logic signed [DIR_W-1:0]  dir_sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= '0;
         period_ff     <= 32'd1000;
         wave_gain_ff  <= 24'd65280;
         dir_cos_ff    <= 16'sd32767;
         dir_sin_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_TIME: start_time_ff <= csr_wdata;
            CSR_PERIOD:     period_ff     <= csr_wdata[PERIOD_W-1:0];
            CSR_WAVE_GAIN:  wave_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_DIR_COS:    dir_cos_ff    <= csr_wdata[DIR_W-1:0];
            CSR_DIR_SIN:    dir_sin_ff    <= csr_wdata[DIR_W-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic out_valid_ff;
   assign en = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // input stage
   tag_type           s0_tag_ff;
   logic [TIME_W-1:0] s0_elapsed_ff;
   logic [POS_W-1:0]  s0_pos_x_ff;
   logic [POS_W-1:0]  s0_pos_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_tag_ff <= '0;
      end else if (en) begin
         s0_tag_ff <= '{valid: req_chan.valid, last: req_chan.last_led};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_elapsed_ff <= req_chan.now_ms - start_time_ff;
         s0_pos_x_ff   <= req_chan.pos_x;
         s0_pos_y_ff   <= req_chan.pos_y;
      end
   end

   tag_type              div_tag;
   logic [PHASE_W-1:0]   tphase;
   logic signed [TERM_W-1:0] term;

   lwpg_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_tag     (s0_tag_ff),
      .in_elapsed (s0_elapsed_ff),
      .period     (period_ff),
      .out_tag    (div_tag),
      .out_tphase (tphase)
   );

   lwpg_proj u_proj (
      .clock     (clock),
      .en        (en),
      .pos_x     (s0_pos_x_ff),
      .pos_y     (s0_pos_y_ff),
      .dir_cos   (dir_cos_ff),
      .dir_sin   (dir_sin_ff),
      .wave_gain (wave_gain_ff),
      .term      (term)
   );

   // hold the projection term until the divider catches up
   logic signed [TERM_W-1:0] tdly_ff [TERM_DLY];
   always_ff @(posedge clock) begin
      if (en) begin
         tdly_ff[0] <= term;
         for (int i = 1; i < TERM_DLY; i++) begin
            tdly_ff[i] <= tdly_ff[i-1];
         end
      end
   end

   // fold mod 255 using 256 = 1
   logic signed [20:0] sum;
   logic [18:0]        vpos;
   logic [11:0]        f1_in, f1_ff;
   tag_type            f1_tag_ff;
   logic [8:0]         f2;
   logic [PHASE_W-1:0] phase_in, phase_ff;
   logic               frame_end_ff;

   assign sum   = $signed({13'd0, tphase}) + 21'sd256 - 21'(tdly_ff[TERM_DLY-1])
                  + $signed({2'b00, MOD_OFFSET});
   assign vpos  = sum[18:0];
   assign f1_in = {1'b0, vpos[18:8]} + {4'd0, vpos[7:0]};
   assign f2    = {5'd0, f1_ff[11:8]} + {1'b0, f1_ff[7:0]};
   assign phase_in = (f2 >= 9'd255) ? 8'(f2 - 9'd255) : f2[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_tag_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         f1_tag_ff    <= div_tag;
         out_valid_ff <= f1_tag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff        <= f1_in;
         phase_ff     <= phase_in;
         frame_end_ff <= f1_tag_ff.last;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.phase     = phase_ff;
   assign rsp_chan.frame_end = frame_end_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.phase != 8'd255)
      else $error("phase word out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result word valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> $stable(f1_tag_ff) && $stable(div_tag))
      else $error("pipeline moved during a stall");

endmodule
